// ===== rtl/fqm_pkg.sv =====
// shared types, codes and sizes for the queue with running maximum
package fqm_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int ITEM_CNT_W = 5;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam val_t NEG_LIMIT = {1'b1, {(VAL_W - 1){1'b0}}};

    // control broadcast to every cell of both chains
    typedef struct packed {
        logic push;
        logic pop_q;
        logic pop_m;
        cnt_t fill;
        cnt_t cand;
        val_t value;
    } ctrl_t;

endpackage

// ===== rtl/fqm_qcell.sv =====
// one slot of the value chain: loads on push at the tail, shifts towards the head on pop
module fqm_qcell (
    input  logic           clk,
    input  fqm_pkg::ctrl_t ctrl,
    input  fqm_pkg::idx_t  idx,
    input  fqm_pkg::val_t  nxt_val,
    output fqm_pkg::val_t  val
);

    fqm_pkg::val_t val_reg;
    fqm_pkg::val_t val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.push && ctrl.fill == {1'b0, idx})
        begin
            val_next = ctrl.value;
        end
        else if (ctrl.pop_q)
        begin
            val_next = nxt_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ===== rtl/fqm_mcell.sv =====
// one slot of the candidate chain: keeps or yields to a pushed value, shifts on head match
module fqm_mcell (
    input  logic           clk,
    input  fqm_pkg::ctrl_t ctrl,
    input  fqm_pkg::idx_t  idx,
    input  logic           keep_prev,
    input  fqm_pkg::val_t  nxt_val,
    output fqm_pkg::val_t  val,
    output logic           keep,
    output logic           load
);

    fqm_pkg::val_t val_reg;
    fqm_pkg::val_t val_next;
    logic          occupied;

    assign occupied = {1'b0, idx} < ctrl.cand;
    // a candidate survives a push unless it is strictly smaller
    assign keep = occupied && !(val_reg < ctrl.value);
    assign load = ctrl.push && !keep && keep_prev;

    always_comb
    begin
        val_next = val_reg;
        if (load)
        begin
            val_next = ctrl.value;
        end
        else if (ctrl.pop_m)
        begin
            val_next = nxt_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ===== rtl/fifo_queue_with_max_core.sv =====
// top level: fifo of signed values with running maximum, built from two cell chains
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------------------
//  in      | in_valid  | in_stall  | command, value
//  out     | out_valid | out_stall | status, popped_value, item_count, max_value, max_valid
//
// one beat in gives one beat out, registered, in the cycle after acceptance
// a new beat is taken every cycle; the single output register stalls the input only
//   while a result sits in it and out_stall is high
// the value chain holds the head in cell 0, the candidate chain holds the maximum in cell 0
// asynchronous active-low reset empties both chains (counts only; cell contents stay)
module fifo_queue_with_max_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        command,
    input  logic signed [fqm_pkg::VAL_W-1:0]  value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic signed [fqm_pkg::VAL_W-1:0]  popped_value,
    output logic [fqm_pkg::ITEM_CNT_W-1:0]    item_count,
    output logic signed [fqm_pkg::VAL_W-1:0]  max_value,
    output logic                              max_valid
);

    // control state
    fqm_pkg::cnt_t fill_reg;
    fqm_pkg::cnt_t fill_next;
    fqm_pkg::cnt_t cand_reg;
    fqm_pkg::cnt_t cand_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    // result register
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    fqm_pkg::val_t popped_reg;
    fqm_pkg::val_t popped_next;
    fqm_pkg::cnt_t count_reg;
    fqm_pkg::val_t max_reg;
    fqm_pkg::val_t max_next;
    logic          max_valid_reg;
    logic          max_valid_next;

    // cell chains
    fqm_pkg::ctrl_t ctrl;
    fqm_pkg::val_t  qval [fqm_pkg::DEPTH];
    fqm_pkg::val_t  mval [fqm_pkg::DEPTH];
    logic           keep [fqm_pkg::DEPTH];
    logic           load [fqm_pkg::DEPTH];

    logic          accept;
    logic          push_ok;
    logic          pop_ok;
    fqm_pkg::cnt_t load_pos;

    // input is held back only while the result register is full and stalled
    assign in_stall = out_valid_reg && out_stall;
    assign accept = in_valid && !in_stall;

    assign push_ok = accept && command == fqm_pkg::CMD_PUSH
                     && fill_reg < fqm_pkg::CNT_W'(fqm_pkg::DEPTH);
    assign pop_ok = accept && command == fqm_pkg::CMD_POP && fill_reg != '0;

    always_comb
    begin
        ctrl.push = push_ok;
        ctrl.pop_q = pop_ok;
        // the front candidate leaves only with the value it came from
        ctrl.pop_m = pop_ok && cand_reg != '0 && mval[0] == qval[0];
        ctrl.fill = fill_reg;
        ctrl.cand = cand_reg;
        ctrl.value = value;
    end

    genvar g;
    generate
        for (g = 0; g < fqm_pkg::DEPTH; g++)
        begin : g_cell
            fqm_pkg::val_t q_nxt;
            fqm_pkg::val_t m_nxt;
            logic          k_prev;

            if (g == fqm_pkg::DEPTH - 1)
            begin : g_last
                assign q_nxt = qval[g];
                assign m_nxt = mval[g];
            end
            else
            begin : g_mid
                assign q_nxt = qval[g + 1];
                assign m_nxt = mval[g + 1];
            end

            if (g == 0)
            begin : g_first
                assign k_prev = 1'b1;
            end
            else
            begin : g_rest
                assign k_prev = keep[g - 1];
            end

            fqm_qcell u_qcell (
                .clk     (clk),
                .ctrl    (ctrl),
                .idx     (fqm_pkg::IDX_W'(g)),
                .nxt_val (q_nxt),
                .val     (qval[g])
            );

            fqm_mcell u_mcell (
                .clk       (clk),
                .ctrl      (ctrl),
                .idx       (fqm_pkg::IDX_W'(g)),
                .keep_prev (k_prev),
                .nxt_val   (m_nxt),
                .val       (mval[g]),
                .keep      (keep[g]),
                .load      (load[g])
            );
        end
    endgenerate

    // position of the cell taking a pushed value (at most one loads)
    always_comb
    begin
        load_pos = '0;
        for (int i = 0; i < fqm_pkg::DEPTH; i++)
        begin
            if (load[i])
            begin
                load_pos = load_pos | fqm_pkg::CNT_W'(i);
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        cand_next = cand_reg;
        if (push_ok)
        begin
            fill_next = fill_reg + fqm_pkg::CNT_W'(1);
            cand_next = load_pos + fqm_pkg::CNT_W'(1);
        end
        else if (pop_ok)
        begin
            fill_next = fill_reg - fqm_pkg::CNT_W'(1);
            if (ctrl.pop_m)
            begin
                cand_next = cand_reg - fqm_pkg::CNT_W'(1);
            end
        end
    end

    // result for the beat, from the state it leaves behind
    always_comb
    begin
        status_next = fqm_pkg::ST_OK;
        if (accept && command == fqm_pkg::CMD_PUSH && !push_ok)
        begin
            status_next = fqm_pkg::ST_FULL;
        end
        else if (accept && command == fqm_pkg::CMD_POP && !pop_ok)
        begin
            status_next = fqm_pkg::ST_EMPTY;
        end

        popped_next = pop_ok ? qval[0] : fqm_pkg::NEG_LIMIT;

        max_valid_next = fill_next != '0 && cand_next != '0;
        if (!max_valid_next)
        begin
            max_next = fqm_pkg::NEG_LIMIT;
        end
        else if (load[0])
        begin
            max_next = value;
        end
        else if (ctrl.pop_m)
        begin
            max_next = mval[1];
        end
        else
        begin
            max_next = mval[0];
        end
    end

    assign out_valid_next = accept || in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            cand_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            cand_reg <= cand_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            popped_reg <= popped_next;
            count_reg <= fill_next;
            max_reg <= max_next;
            max_valid_reg <= max_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign popped_value = popped_reg;
    assign item_count = fqm_pkg::ITEM_CNT_W'(count_reg);
    assign max_value = max_reg;
    assign max_valid = max_valid_reg;

endmodule

// ===== rtl/fqm_chk.sv =====
// port-level checker for the queue with running maximum, bound to the top level
module fqm_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [1:0]                        status,
    input logic signed [fqm_pkg::VAL_W-1:0]  popped_value,
    input logic [fqm_pkg::ITEM_CNT_W-1:0]    item_count,
    input logic signed [fqm_pkg::VAL_W-1:0]  max_value,
    input logic                              max_valid
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(max_value)
                                   && $stable(item_count) && $stable(popped_value))
        else $error("result beat changed under stall");

    // input held back only while a result is waiting
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a waiting result");

    // every accepted input beat shows up as a result beat next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted beat gave no result");

    a_max_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> max_valid == (item_count != '0))
        else $error("max flag disagrees with count");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == fqm_pkg::ST_EMPTY
        |-> item_count == '0 && popped_value == fqm_pkg::NEG_LIMIT
            && !max_valid && max_value == fqm_pkg::NEG_LIMIT)
        else $error("pop on empty with data");

endmodule

bind fifo_queue_with_max_core fqm_chk u_fqm_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .popped_value (popped_value),
    .item_count   (item_count),
    .max_value    (max_value),
    .max_valid    (max_valid)
);

// ===== verif/tb_fifo_queue_with_max_core.sv =====
// testbench for fifo_queue_with_max_core: directed and random beats against a queue predictor
`timescale 1ns / 100ps

module tb_fifo_queue_with_max_core;

    // least number of beats offered in all, directed ones included; the last segment may run past it
    localparam int TOTAL_BEATS = 950;
    // generous bound on run length, well above the slowest legal run
    localparam int CYCLE_LIMIT = 200000;
    localparam fqm_pkg::val_t POS_LIMIT = {1'b0, {(fqm_pkg::VAL_W - 1){1'b1}}};
    // unused command code, handled as a query by the block
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic [1:0]    command;
        fqm_pkg::val_t value;
    } queue_cmd_t;

    typedef struct {
        logic [1:0]                     status;
        fqm_pkg::val_t                  popped_value;
        logic [fqm_pkg::ITEM_CNT_W-1:0] item_count;
        fqm_pkg::val_t                  max_value;
        logic                           max_valid;
    } queue_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [1:0]                     command = fqm_pkg::CMD_QUERY;
    fqm_pkg::val_t                  value = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [1:0]                     status;
    fqm_pkg::val_t                  popped_value;
    logic [fqm_pkg::ITEM_CNT_W-1:0] item_count;
    fqm_pkg::val_t                  max_value;
    logic                           max_valid;

    fifo_queue_with_max_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .popped_value (popped_value),
        .item_count   (item_count),
        .max_value    (max_value),
        .max_valid    (max_valid)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // beats waiting to be offered, and results waiting to come out
    queue_cmd_t    pending_cmds[$];
    queue_result_t expected_results[$];

    // predictor state: values held, head first, and the nonincreasing candidate list
    fqm_pkg::val_t model_values[$];
    fqm_pkg::val_t model_cands[$];

    int   total_cmds;
    int   cmds_taken;
    int   results_seen;
    int   mismatches;
    int   cycles;

    // handshake flags raised at the rising edge, consumed at the falling edge
    bit   in_taken;
    bit   out_taken;
    bit   hold_off;

    int   in_gap;
    int   in_calm_left;
    bit   in_calm;
    int   out_wait;
    int   out_calm_left;
    bit   out_calm;

    queue_result_t got_result;
    queue_result_t want_result;

    // work out the result of one command and advance the predictor
    function automatic queue_result_t predict_queue_step(logic [1:0] cmd, fqm_pkg::val_t val);
        queue_result_t r;
        r.status = fqm_pkg::ST_OK;
        r.popped_value = fqm_pkg::NEG_LIMIT;
        if (cmd == fqm_pkg::CMD_PUSH)
        begin
            if (model_values.size() >= fqm_pkg::DEPTH)
                r.status = fqm_pkg::ST_FULL;
            else
            begin
                model_values.push_back(val);
                // smaller trailing candidates can never be the maximum again
                while (model_cands.size() > 0 && model_cands[$] < val)
                    void'(model_cands.pop_back());
                if (model_cands.size() < fqm_pkg::DEPTH)
                    model_cands.push_back(val);
            end
        end
        else if (cmd == fqm_pkg::CMD_POP)
        begin
            if (model_values.size() == 0)
                r.status = fqm_pkg::ST_EMPTY;
            else
            begin
                r.popped_value = model_values.pop_front();
                if (model_cands.size() > 0 && model_cands[0] == r.popped_value)
                    void'(model_cands.pop_front());
            end
        end
        r.item_count = fqm_pkg::ITEM_CNT_W'(model_values.size());
        if (model_values.size() > 0 && model_cands.size() > 0)
        begin
            r.max_value = model_cands[0];
            r.max_valid = 1'b1;
        end
        else
        begin
            r.max_value = fqm_pkg::NEG_LIMIT;
            r.max_valid = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %h, expected %h", results_seen, field, got, want);
        mismatches++;
    endtask

    task automatic add_cmd(logic [1:0] cmd, fqm_pkg::val_t val);
        queue_cmd_t c;
        c.command = cmd;
        c.value = val;
        pending_cmds.push_back(c);
    endtask

    // sender: updates at the falling edge, holds the payload while stalled
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                in_valid <= 1'b1;
                command <= pending_cmds[0].command;
                value <= pending_cmds[0].value;
                void'(pending_cmds.pop_front());
                // mix stretches with no gaps and stretches with random gaps, each kind picked at random
                if (in_calm_left == 0)
                begin
                    in_calm = ($urandom_range(0, 3) == 0);
                    in_calm_left = $urandom_range(5, 40);
                end
                in_calm_left--;
                in_gap = in_calm ? 0 : $urandom_range(0, 11);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: stall drawn per beat, plus the long hold-off when asked for
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                if (out_calm_left == 0)
                begin
                    out_calm = ($urandom_range(0, 3) == 0);
                    out_calm_left = $urandom_range(5, 40);
                end
                out_calm_left--;
                out_wait = out_calm ? 0 : $urandom_range(0, 11);
            end
            if (hold_off)
                out_stall <= 1'b1;
            else if (out_wait > 0)
            begin
                out_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // monitor: predicts on every accepted input beat, checks every accepted output beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(predict_queue_step(command, value));
                cmds_taken++;
                in_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                out_taken = 1'b1;
                got_result.status = status;
                got_result.popped_value = popped_value;
                got_result.item_count = item_count;
                got_result.max_value = max_value;
                got_result.max_valid = max_valid;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected beat, status", 32'(status), 32'(0));
                else
                begin
                    want_result = expected_results.pop_front();
                    if (got_result.status !== want_result.status)
                        report_mismatch("status", 32'(got_result.status),
                                        32'(want_result.status));
                    if (got_result.popped_value !== want_result.popped_value)
                        report_mismatch("popped_value", got_result.popped_value,
                                        want_result.popped_value);
                    if (got_result.item_count !== want_result.item_count)
                        report_mismatch("item_count", 32'(got_result.item_count),
                                        32'(want_result.item_count));
                    if (got_result.max_value !== want_result.max_value)
                        report_mismatch("max_value", got_result.max_value,
                                        want_result.max_value);
                    if (got_result.max_valid !== want_result.max_valid)
                        report_mismatch("max_valid", 32'(got_result.max_valid),
                                        32'(want_result.max_valid));
                end
                results_seen++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // long receiver hold-offs so that the output register fills and the input stalls
    initial
    begin
        wait (results_seen >= 150);
        hold_off = 1'b1;
        repeat (80) @(posedge clk);
        hold_off = 1'b0;
        wait (results_seen >= 600);
        hold_off = 1'b1;
        repeat (120) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        int            seg_len;
        int            push_pct;
        int            val_style;
        int            r;
        fqm_pkg::val_t ramp;
        fqm_pkg::val_t v;
        logic [1:0]    cmd;

        // directed: empty pop and queries first
        add_cmd(fqm_pkg::CMD_POP, 32'sd0);
        add_cmd(fqm_pkg::CMD_QUERY, POS_LIMIT);
        add_cmd(CMD_SPARE, fqm_pkg::NEG_LIMIT);
        // fill to the top with extremes and repeated maxima
        add_cmd(fqm_pkg::CMD_PUSH, 32'sd5);
        add_cmd(fqm_pkg::CMD_PUSH, 32'sd5);
        add_cmd(fqm_pkg::CMD_PUSH, fqm_pkg::NEG_LIMIT);
        add_cmd(fqm_pkg::CMD_PUSH, -32'sd1);
        add_cmd(fqm_pkg::CMD_PUSH, 32'sd0);
        add_cmd(fqm_pkg::CMD_PUSH, POS_LIMIT);
        add_cmd(fqm_pkg::CMD_PUSH, POS_LIMIT);
        add_cmd(fqm_pkg::CMD_PUSH, 32'sd3);
        add_cmd(fqm_pkg::CMD_PUSH, 32'sd3);
        add_cmd(fqm_pkg::CMD_PUSH, fqm_pkg::NEG_LIMIT + 1);
        add_cmd(fqm_pkg::CMD_PUSH, 32'sd1);
        add_cmd(fqm_pkg::CMD_PUSH, 32'h5555_5555);
        add_cmd(fqm_pkg::CMD_PUSH, 32'hAAAA_AAAA);
        add_cmd(fqm_pkg::CMD_PUSH, 32'sd7);
        add_cmd(fqm_pkg::CMD_PUSH, 32'sd7);
        add_cmd(fqm_pkg::CMD_PUSH, 32'sd6);
        // push on a full queue is dropped
        add_cmd(fqm_pkg::CMD_PUSH, -32'sd7);
        add_cmd(fqm_pkg::CMD_QUERY, 32'sd0);
        add_cmd(fqm_pkg::CMD_POP, 32'sd0);
        add_cmd(fqm_pkg::CMD_POP, 32'sd0);
        add_cmd(fqm_pkg::CMD_POP, 32'sd0);
        add_cmd(fqm_pkg::CMD_POP, 32'sd0);

        // random: segments biased to fill, drain or churn, with varied value styles
        ramp = '0;
        while (pending_cmds.size() < TOTAL_BEATS)
        begin
            seg_len = $urandom_range(10, 50);
            case ($urandom_range(0, 2))
                0: push_pct = 80;
                1: push_pct = 20;
                default: push_pct = 50;
            endcase
            val_style = $urandom_range(0, 4);
            ramp = $urandom;
            repeat (seg_len)
            begin
                r = $urandom_range(0, 99);
                if (r < push_pct)
                    cmd = fqm_pkg::CMD_PUSH;
                else if (r < 95)
                    cmd = fqm_pkg::CMD_POP;
                else if (r < 98)
                    cmd = fqm_pkg::CMD_QUERY;
                else
                    cmd = CMD_SPARE;
                case (val_style)
                    0: v = $urandom;
                    1: v = $signed($urandom_range(0, 8)) - 32'sd4;
                    2:
                    begin
                        case ($urandom_range(0, 4))
                            0: v = POS_LIMIT;
                            1: v = fqm_pkg::NEG_LIMIT;
                            2: v = 32'sd0;
                            3: v = -32'sd1;
                            default: v = 32'sd1;
                        endcase
                    end
                    3:
                    begin
                        ramp = ramp + $urandom_range(0, 3);
                        v = ramp;
                    end
                    default:
                    begin
                        ramp = ramp - $urandom_range(0, 3);
                        v = ramp;
                    end
                endcase
                add_cmd(cmd, v);
            end
        end
        total_cmds = pending_cmds.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (cmds_taken == total_cmds);
        wait (expected_results.size() == 0);
        // run on for any stray beats before the verdict
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
